### sv/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types, codes and defaults for the fixed partition allocator.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int PARTITIONS  = 4;
    localparam int PART_IDX_W  = 2;
    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int ID_W    = 16;
    localparam int SIZE_W  = 17;
    localparam int ADDR_W  = 16;
    localparam int LEN_W   = 16;
    localparam int MEM_W   = 17;
    localparam int STAT_W  = 3;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] REG_MEMORY_SIZE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_FIRST  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_SECOND = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_THIRD  = 2'd3;

    localparam logic [MEM_W-1:0] MEMORY_SIZE_RST   = 17'd65536;
    localparam logic [LEN_W-1:0] LENGTH_FIRST_RST  = 16'd10484;
    localparam logic [LEN_W-1:0] LENGTH_SECOND_RST = 16'd12320;
    localparam logic [LEN_W-1:0] LENGTH_THIRD_RST  = 16'd14745;

    // item modes
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_PLACED     = 3'd0;
    localparam logic [STAT_W-1:0] ST_QUEUED     = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_FIT     = 3'd2;
    localparam logic [STAT_W-1:0] ST_QUEUE_FULL = 3'd3;
    localparam logic [STAT_W-1:0] ST_PROMOTED   = 3'd4;
    localparam logic [STAT_W-1:0] ST_REL_IDLE   = 3'd5;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd6;

    typedef struct packed {
        logic              mode;
        logic [ID_W-1:0]   process_id;
        logic [SIZE_W-1:0] process_size;
    } item_t;

    typedef struct packed {
        logic [STAT_W-1:0]     status;
        logic [PART_IDX_W-1:0] partition_index;
        logic [ADDR_W-1:0]     begin_address;
        logic [ADDR_W-1:0]     end_address;
        logic [ID_W-1:0]       promoted_id;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic finish_pop;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pop_needed;
    } dp_stat_t;

endpackage

### sv/fpa_ram.sv
// ----------------------------------------------------------------------------
// fpa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/fpa_ctrl.sv
// ----------------------------------------------------------------------------
// fpa_ctrl
// Sequencer: takes one item, runs it through the datapath, owns the
// result valid flag.
// ----------------------------------------------------------------------------
module fpa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output fpa_pkg::ctrl_cmd_t cmd,
    input  fpa_pkg::dp_stat_t  stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;
    logic       load_out;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        load_out   = 1'b0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                // no beat is taken while in reset
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold the item until the result register can take it
                if (out_free) begin
                    cmd.execute = 1'b1;
                    if (stat.pop_needed) begin
                        state_next = S_POP;
                    end else begin
                        load_out   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_POP: begin
                cmd.finish_pop = 1'b1;
                load_out       = 1'b1;
                state_next     = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### sv/fpa_dp.sv
// ----------------------------------------------------------------------------
// fpa_dp
// Datapath: configuration, partition geometry, partition state, wait
// queues in one RAM, and the result register.
// ----------------------------------------------------------------------------
module fpa_dp #(
    parameter int QUEUE_DEPTH = fpa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [fpa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fpa_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  fpa_pkg::item_t                      s_data,
    output fpa_pkg::result_t                    m_data,
    input  fpa_pkg::ctrl_cmd_t                  cmd,
    output fpa_pkg::dp_stat_t                   stat
);

    localparam int NP  = fpa_pkg::PARTITIONS;
    localparam int PIW = fpa_pkg::PART_IDX_W;
    localparam int IDW = fpa_pkg::ID_W;
    localparam int AW  = $clog2(NP * QUEUE_DEPTH);
    localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);

    // configuration
    logic [fpa_pkg::MEM_W-1:0] mem_size_reg;
    logic [fpa_pkg::LEN_W-1:0] len_first_reg, len_second_reg, len_third_reg;

    // geometry, refreshed every cycle from the configuration
    logic [16:0] b2_reg, b2_next;
    logic [17:0] b3_reg, b3_next;
    logic [16:0] len3_reg, len3_next;

    fpa_pkg::item_t   item_reg;
    fpa_pkg::result_t out_reg, out_next;

    logic           occ_reg  [NP];
    logic           occ_next [NP];
    logic [IDW-1:0] run_reg  [NP];
    logic [IDW-1:0] run_next [NP];
    logic [PW-1:0]  head_reg [NP];
    logic [PW-1:0]  head_next[NP];
    logic [PW-1:0]  tail_reg [NP];
    logic [PW-1:0]  tail_next[NP];
    logic [CW-1:0]  cnt_reg  [NP];
    logic [CW-1:0]  cnt_next [NP];
    logic [PIW-1:0] pop_part_reg, pop_part_next;

    logic [16:0]          len_w  [NP];
    logic [15:0]          beg_w  [NP];
    logic                 alloc_found, rel_found, found;
    logic [PIW-1:0]       alloc_idx, rel_idx, hit;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [IDW-1:0]       ram_rdata;

    // -------------------------------------------------------------- config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_size_reg   <= fpa_pkg::MEMORY_SIZE_RST;
            len_first_reg  <= fpa_pkg::LENGTH_FIRST_RST;
            len_second_reg <= fpa_pkg::LENGTH_SECOND_RST;
            len_third_reg  <= fpa_pkg::LENGTH_THIRD_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                fpa_pkg::REG_MEMORY_SIZE:   mem_size_reg   <= cfg_data;
                fpa_pkg::REG_LENGTH_FIRST:  len_first_reg  <= cfg_data[15:0];
                fpa_pkg::REG_LENGTH_SECOND: len_second_reg <= cfg_data[15:0];
                fpa_pkg::REG_LENGTH_THIRD:  len_third_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        b2_next   = 17'(len_first_reg) + 17'(len_second_reg);
        b3_next   = 18'(len_first_reg) + 18'(len_second_reg) + 18'(len_third_reg);
        len3_next = (18'(mem_size_reg) > b3_next) ? 17'(18'(mem_size_reg) - b3_next)
                                                  : 17'd0;
    end

    always_ff @(posedge aclk) begin
        b2_reg   <= b2_next;
        b3_reg   <= b3_next;
        len3_reg <= len3_next;
    end

    // ------------------------------------------------------------ matching
    always_comb begin
        len_w[0] = 17'(len_first_reg);
        len_w[1] = 17'(len_second_reg);
        len_w[2] = 17'(len_third_reg);
        len_w[3] = len3_reg;
        beg_w[0] = 16'd0;
        beg_w[1] = len_first_reg;
        beg_w[2] = b2_reg[15:0];
        beg_w[3] = b3_reg[15:0];

        alloc_found = 1'b0;
        alloc_idx   = '0;
        rel_found   = 1'b0;
        rel_idx     = '0;
        // walk downward so the lowest index wins
        for (int p = NP - 1; p >= 0; p--) begin
            if (item_reg.process_size <= len_w[p]) begin
                alloc_found = 1'b1;
                alloc_idx   = PIW'(p);
            end
            if (occ_reg[p] && run_reg[p] == item_reg.process_id) begin
                rel_found = 1'b1;
                rel_idx   = PIW'(p);
            end
        end
        found = (item_reg.mode == fpa_pkg::MODE_RELEASE) ? rel_found : alloc_found;
        hit   = (item_reg.mode == fpa_pkg::MODE_RELEASE) ? rel_idx : alloc_idx;
    end

    assign stat.pop_needed = (item_reg.mode == fpa_pkg::MODE_RELEASE) && rel_found
                             && (cnt_reg[rel_idx] != '0);

    // ----------------------------------------------------------- execution
    always_comb begin
        occ_next      = occ_reg;
        run_next      = run_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        cnt_next      = cnt_reg;
        pop_part_next = pop_part_reg;
        out_next      = out_reg;
        ram_we        = 1'b0;
        ram_waddr     = AW'(AW'(hit) * AW'(QUEUE_DEPTH)) + AW'(tail_reg[hit]);
        ram_raddr     = AW'(AW'(hit) * AW'(QUEUE_DEPTH)) + AW'(head_reg[hit]);

        if (cmd.execute) begin
            out_next                 = '0;
            out_next.partition_index = found ? hit : '0;
            if (item_reg.mode == fpa_pkg::MODE_ALLOC) begin
                if (!found) begin
                    out_next.status = fpa_pkg::ST_NO_FIT;
                end else if (!occ_reg[hit]) begin
                    occ_next[hit]          = 1'b1;
                    run_next[hit]          = item_reg.process_id;
                    out_next.status        = fpa_pkg::ST_PLACED;
                    out_next.begin_address = beg_w[hit];
                    out_next.end_address   = 16'(beg_w[hit] + item_reg.process_size[15:0]
                                                 - 16'd1);
                end else if (cnt_reg[hit] >= CW'(QUEUE_DEPTH)) begin
                    out_next.status = fpa_pkg::ST_QUEUE_FULL;
                end else begin
                    ram_we          = 1'b1;
                    tail_next[hit]  = (tail_reg[hit] == PW'(QUEUE_DEPTH - 1)) ? '0
                                      : PW'(tail_reg[hit] + 1'b1);
                    cnt_next[hit]   = CW'(cnt_reg[hit] + 1'b1);
                    out_next.status = fpa_pkg::ST_QUEUED;
                end
            end else begin
                if (!found) begin
                    out_next.status = fpa_pkg::ST_NOT_FOUND;
                end else if (cnt_reg[hit] != '0) begin
                    // queue head is read now and lands in the next cycle
                    head_next[hit]  = (head_reg[hit] == PW'(QUEUE_DEPTH - 1)) ? '0
                                      : PW'(head_reg[hit] + 1'b1);
                    cnt_next[hit]   = CW'(cnt_reg[hit] - 1'b1);
                    pop_part_next   = hit;
                    out_next.status = fpa_pkg::ST_PROMOTED;
                end else begin
                    occ_next[hit]   = 1'b0;
                    out_next.status = fpa_pkg::ST_REL_IDLE;
                end
            end
        end

        if (cmd.finish_pop) begin
            run_next[pop_part_reg] = ram_rdata;
            out_next.promoted_id   = ram_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < NP; p++) begin
                occ_reg[p]  <= 1'b0;
                run_reg[p]  <= '0;
                head_reg[p] <= '0;
                tail_reg[p] <= '0;
                cnt_reg[p]  <= '0;
            end
            pop_part_reg <= '0;
        end else begin
            occ_reg      <= occ_next;
            run_reg      <= run_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            cnt_reg      <= cnt_next;
            pop_part_reg <= pop_part_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        out_reg <= out_next;
    end

    fpa_ram #(
        .WIDTH (IDW),
        .DEPTH (NP * QUEUE_DEPTH)
    ) u_queue_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item_reg.process_id),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_data = out_reg;

endmodule

### sv/fixed_partition_allocator.sv
// ----------------------------------------------------------------------------
// fixed_partition_allocator
// Four fixed partitions with a wait queue each; allocate and release
// items give one result beat each.
// ----------------------------------------------------------------------------
//  channel | ports                               | direction
//  --------+-------------------------------------+----------
//  input   | s_valid, s_ready, s_data (item_t)   | in
//  result  | m_valid, m_ready, m_data (result_t) | out
//  config  | cfg_valid, cfg_ready, cfg_index,    | in
//          | cfg_data                            |
//
// One item at a time: accept, execute, and for a release that promotes a
// queued id a further pop step for the queue RAM's registered read. The
// execute step waits while the previous result beat is still held in the
// output register.
// Reset (aresetn low, synchronous) clears partitions, queue pointers and
// restores the configuration defaults; queue contents need no clearing.
// Config writes are accepted in every cycle out of reset.
// ----------------------------------------------------------------------------
module fixed_partition_allocator #(
    parameter int QUEUE_DEPTH = fpa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  fpa_pkg::item_t                  s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output fpa_pkg::result_t                m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fpa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fpa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    fpa_pkg::ctrl_cmd_t cmd;
    fpa_pkg::dp_stat_t  stat;

    assign cfg_ready = aresetn;

    fpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    fpa_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    // one item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice in a row");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= fpa_pkg::ST_NOT_FOUND)
        else $error("result status out of range");

    a_promoted_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != fpa_pkg::ST_PROMOTED |-> m_data.promoted_id == '0)
        else $error("promoted id set without promotion");

    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != fpa_pkg::ST_PLACED
        |-> m_data.begin_address == '0 && m_data.end_address == '0)
        else $error("addresses set without placement");

    a_idx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == fpa_pkg::ST_NO_FIT
                    || m_data.status == fpa_pkg::ST_NOT_FOUND)
        |-> m_data.partition_index == '0)
        else $error("partition index set without a match");

endmodule
